[hdl/local_peak_valley_in_window_macros.svh]
// Assertion macros shared by the checker of the local peak/valley search.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LOCAL_PEAK_VALLEY_IN_WINDOW_MACROS_SVH
`define LOCAL_PEAK_VALLEY_IN_WINDOW_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define LPV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated off during reset.
`define LPV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lpv_pkg.sv]
// Shared types and constants for the local peak/valley search.
// No dependencies; used by the interfaces, the judge and the top level.
package lpv_pkg;

  localparam int TIME_BITS      = 32;
  localparam int ACTUAL_BITS    = 32;
  localparam int DISPLAY_BITS   = 16;
  localparam int INDEX_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CENTER_TIME  = 2'd0,
    CFG_MAX_DISTANCE = 2'd1,
    CFG_EXTREME_KIND = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_PEAK   = 1'b0,
    KIND_VALLEY = 1'b1
  } kind_t;

  typedef struct packed {
    logic                 take;
    logic [TIME_BITS-1:0] gap;
  } judge_t;

endpackage

[hdl/lpv_sample_if.sv]
// Sample stream channel: valid/ready plus one sample word.
// Depends on lpv_pkg for field widths.
interface lpv_sample_if #(
  parameter int VALUE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [lpv_pkg::TIME_BITS-1:0]       sample_time;
  logic signed [VALUE_BITS-1:0]        sample_value;
  logic signed [lpv_pkg::ACTUAL_BITS-1:0] actual_value;
  logic                                has_actual;
  logic                                usable;
  logic                                last_sample;

  modport source (output valid, sample_time, sample_value, actual_value, has_actual,
                  usable, last_sample, input ready);
  modport sink (input valid, sample_time, sample_value, actual_value, has_actual,
                usable, last_sample, output ready);
endinterface

[hdl/lpv_result_if.sv]
// Result channel: valid/ready plus one search result word.
// Depends on lpv_pkg for field widths.
interface lpv_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    found;
  logic [lpv_pkg::INDEX_BITS-1:0]          hit_index;
  logic [lpv_pkg::TIME_BITS-1:0]           hit_time;
  logic signed [lpv_pkg::DISPLAY_BITS-1:0] hit_display;
  logic signed [lpv_pkg::ACTUAL_BITS-1:0]  hit_actual;

  modport source (output valid, found, hit_index, hit_time, hit_display, hit_actual,
                  input ready);
  modport sink (input valid, found, hit_index, hit_time, hit_display, hit_actual,
                output ready);
endinterface

[hdl/lpv_cfg_if.sv]
// Configuration write channel: valid/ready, register index and data.
// Depends on lpv_pkg for field widths.
interface lpv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpv_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [lpv_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/lpv_judge.sv]
// Decides whether the window's middle sample replaces the kept candidate.
// Depends on lpv_pkg (judge_t, kind_t). Purely combinational.
module lpv_judge #(
  parameter int VALUE_BITS = 16
) (
  input  logic                               window_full,
  input  logic signed [VALUE_BITS-1:0]       older_value,
  input  logic                               older_ok,
  input  logic [lpv_pkg::TIME_BITS-1:0]      mid_time,
  input  logic signed [VALUE_BITS-1:0]       mid_value,
  input  logic                               mid_ok,
  input  logic signed [VALUE_BITS-1:0]       next_value,
  input  logic                               next_ok,
  input  logic [lpv_pkg::TIME_BITS-1:0]      center_time,
  input  logic [lpv_pkg::TIME_BITS-1:0]      max_distance,
  input  lpv_pkg::kind_t                     kind,
  input  logic                               best_valid,
  input  logic signed [VALUE_BITS-1:0]       best_display,
  input  logic [lpv_pkg::TIME_BITS-1:0]      best_distance,
  output lpv_pkg::judge_t                    verdict
);

  logic [lpv_pkg::TIME_BITS-1:0] gap;
  logic in_range;
  logic is_extreme;
  logic beats_best;
  logic qualifies;

  always_comb begin
    gap = (mid_time >= center_time) ? (mid_time - center_time) : (center_time - mid_time);
    in_range = (max_distance != '0) && (gap <= max_distance);
    if (kind == lpv_pkg::KIND_PEAK) begin
      is_extreme = (mid_value > older_value) && (mid_value > next_value);
      beats_best = mid_value > best_display;
    end else begin
      is_extreme = (mid_value < older_value) && (mid_value < next_value);
      beats_best = mid_value < best_display;
    end
    qualifies = window_full && older_ok && mid_ok && next_ok && in_range && is_extreme;
    verdict.gap = gap;
    // tie on value goes to the strictly nearer sample
    verdict.take = qualifies &&
                   (!best_valid || beats_best ||
                    ((mid_value == best_display) && (gap < best_distance)));
  end

endmodule

[hdl/local_peak_valley_in_window.sv]
// Local peak/valley search over one channel's sample stream. The block takes one sample
// word per clock and keeps a three-sample window plus the best candidate so far; the
// sample flagged last_sample closes the stream, and its result word is presented from the
// result register once that sample has passed the input register. One input register and
// one result register bracket the compare logic, so the sustained rate is one sample per
// cycle; it drops only while a finished result waits at the output and the next last
// sample would overwrite it.
// Depends on lpv_pkg, lpv_sample_if, lpv_result_if, lpv_cfg_if and lpv_judge.
module local_peak_valley_in_window #(
  parameter int MAX_SAMPLES = 65536,
  parameter int VALUE_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  lpv_sample_if.sink   samples,
  lpv_result_if.source result,
  lpv_cfg_if.sink      cfg
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int TB = lpv_pkg::TIME_BITS;
  localparam int AB = lpv_pkg::ACTUAL_BITS;
  localparam int IB = lpv_pkg::INDEX_BITS;

  // configuration
  logic [TB-1:0]  center_time;
  logic [TB-1:0]  max_distance;
  lpv_pkg::kind_t extreme_kind;

  // input register
  logic                         s1_valid;
  logic [TB-1:0]                s1_time;
  logic signed [VALUE_BITS-1:0] s1_value;
  logic signed [AB-1:0]         s1_actual;
  logic                         s1_has_actual;
  logic                         s1_ok;
  logic                         s1_last;

  // window and candidate
  logic signed [VALUE_BITS-1:0] older_value;
  logic                         older_ok;
  logic [TB-1:0]                mid_time;
  logic signed [VALUE_BITS-1:0] mid_value;
  logic signed [AB-1:0]         mid_actual;
  logic                         mid_has_actual;
  logic                         mid_ok;
  logic [CW-1:0]                sample_count;
  logic                         best_valid;
  logic [IB-1:0]                best_index;
  logic [TB-1:0]                best_time;
  logic signed [VALUE_BITS-1:0] best_display;
  logic signed [AB-1:0]         best_actual;
  logic [TB-1:0]                best_distance;

  logic                         best_valid_next;
  logic [IB-1:0]                best_index_next;
  logic [TB-1:0]                best_time_next;
  logic signed [VALUE_BITS-1:0] best_display_next;
  logic signed [AB-1:0]         best_actual_next;
  logic [TB-1:0]                best_distance_next;

  // result register
  logic                                    out_valid;
  logic                                    out_found;
  logic [IB-1:0]                           out_index;
  logic [TB-1:0]                           out_time;
  logic signed [lpv_pkg::DISPLAY_BITS-1:0] out_display;
  logic signed [AB-1:0]                    out_actual;

  logic            s1_advance;
  logic            s1_fire;
  logic            room;
  logic            take;
  logic [CW-1:0]   mid_index;
  logic signed [AB-1:0] disp_ext;
  logic signed [AB-1:0] mid_value_ext;
  lpv_pkg::judge_t verdict;

  // a last word may only proceed when the result register is free or draining
  assign s1_advance    = !s1_last || !out_valid || result.ready;
  assign s1_fire       = s1_valid && s1_advance;
  assign samples.ready = !s1_valid || s1_advance;
  assign cfg.ready     = 1'b1;

  assign room      = sample_count < CW'(MAX_SAMPLES);
  assign mid_index = sample_count - CW'(1);

  lpv_judge #(
    .VALUE_BITS(VALUE_BITS)
  ) u_judge (
    .window_full  (sample_count >= CW'(2)),
    .older_value  (older_value),
    .older_ok     (older_ok),
    .mid_time     (mid_time),
    .mid_value    (mid_value),
    .mid_ok       (mid_ok),
    .next_value   (s1_value),
    .next_ok      (s1_ok),
    .center_time  (center_time),
    .max_distance (max_distance),
    .kind         (extreme_kind),
    .best_valid   (best_valid),
    .best_display (best_display),
    .best_distance(best_distance),
    .verdict      (verdict)
  );

  assign take          = room && verdict.take;
  assign mid_value_ext = AB'(mid_value);

  always_comb begin
    best_valid_next    = best_valid;
    best_index_next    = best_index;
    best_time_next     = best_time;
    best_display_next  = best_display;
    best_actual_next   = best_actual;
    best_distance_next = best_distance;
    if (take) begin
      best_valid_next    = 1'b1;
      best_index_next    = IB'(mid_index);
      best_time_next     = mid_time;
      best_display_next  = mid_value;
      best_actual_next   = mid_has_actual ? mid_actual : mid_value_ext;
      best_distance_next = verdict.gap;
    end
    disp_ext = AB'(best_display_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_time  <= '0;
      max_distance <= '0;
      extreme_kind <= lpv_pkg::KIND_PEAK;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lpv_pkg::CFG_CENTER_TIME:  center_time  <= cfg.data[TB-1:0];
        lpv_pkg::CFG_MAX_DISTANCE: max_distance <= cfg.data[TB-1:0];
        lpv_pkg::CFG_EXTREME_KIND: extreme_kind <= lpv_pkg::kind_t'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      s1_time       <= samples.sample_time;
      s1_value      <= samples.sample_value;
      s1_actual     <= samples.actual_value;
      s1_has_actual <= samples.has_actual;
      s1_ok         <= samples.usable;
      s1_last       <= samples.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      older_value    <= '0;
      older_ok       <= 1'b0;
      mid_time       <= '0;
      mid_value      <= '0;
      mid_actual     <= '0;
      mid_has_actual <= 1'b0;
      mid_ok         <= 1'b0;
      sample_count   <= '0;
      best_valid     <= 1'b0;
      best_index     <= '0;
      best_time      <= '0;
      best_display   <= '0;
      best_actual    <= '0;
      best_distance  <= '1;
    end else if (s1_fire && room) begin
      older_value    <= mid_value;
      older_ok       <= mid_ok;
      mid_time       <= s1_time;
      mid_value      <= s1_value;
      mid_actual     <= s1_actual;
      mid_has_actual <= s1_has_actual;
      mid_ok         <= s1_ok;
      sample_count   <= sample_count + CW'(1);
      best_valid     <= best_valid_next;
      best_index     <= best_index_next;
      best_time      <= best_time_next;
      best_display   <= best_display_next;
      best_actual    <= best_actual_next;
      best_distance  <= best_distance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      out_found <= best_valid_next;
      // zero every field when nothing qualified
      if (best_valid_next) begin
        out_index   <= best_index_next;
        out_time    <= best_time_next;
        out_display <= disp_ext[lpv_pkg::DISPLAY_BITS-1:0];
        out_actual  <= best_actual_next;
      end else begin
        out_index   <= '0;
        out_time    <= '0;
        out_display <= '0;
        out_actual  <= '0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = out_found;
  assign result.hit_index   = out_index;
  assign result.hit_time    = out_time;
  assign result.hit_display = out_display;
  assign result.hit_actual  = out_actual;

endmodule

[hdl/lpv_checker.sv]
// Port-level checks for the local peak/valley search, bound to the top level.
// Depends on local_peak_valley_in_window_macros.svh and lpv_pkg.
`include "local_peak_valley_in_window_macros.svh"

module lpv_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    in_last,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic                                    found,
  input logic [lpv_pkg::INDEX_BITS-1:0]          hit_index,
  input logic [lpv_pkg::TIME_BITS-1:0]           hit_time,
  input logic signed [lpv_pkg::DISPLAY_BITS-1:0] hit_display,
  input logic signed [lpv_pkg::ACTUAL_BITS-1:0]  hit_actual
);

  `LPV_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && !found, (hit_index == '0) && (hit_time == '0) && (hit_display == '0) && (hit_actual == '0), "result without hit has nonzero fields")

  `LPV_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without output back pressure")

  `LPV_ASSERT_NOW(a_rise_after_last, clk, rst, $rose(out_valid), $past(in_valid && in_ready && in_last, 2), "result appeared without a last word two cycles back")

  `LPV_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready, out_valid && $stable(found) && $stable(hit_index) && $stable(hit_time) && $stable(hit_display) && $stable(hit_actual), "stalled result changed")

endmodule

bind local_peak_valley_in_window lpv_checker u_lpv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_last    (samples.last_sample),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .found      (result.found),
  .hit_index  (result.hit_index),
  .hit_time   (result.hit_time),
  .hit_display(result.hit_display),
  .hit_actual (result.hit_actual)
);

[sim/lpv_hit_checker.sv]
// Checker for the local peak/valley search: watches the sample, result and register
// channels, predicts each result word from the accepted samples and compares field by field.
// Depends on lpv_pkg, lpv_sample_if, lpv_result_if and lpv_cfg_if.
module lpv_hit_checker (
  input  logic  clk,
  input  logic  rst,
  lpv_sample_if smp,
  lpv_result_if res,
  lpv_cfg_if    cfg,
  output int    fail_count,
  output int    pending,
  output int    results_seen,
  output int    hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_CAP = 65536;

  typedef struct packed {
    logic                                    found;
    logic [lpv_pkg::INDEX_BITS-1:0]          index;
    logic [lpv_pkg::TIME_BITS-1:0]           stamp;
    logic signed [lpv_pkg::DISPLAY_BITS-1:0] display;
    logic signed [lpv_pkg::ACTUAL_BITS-1:0]  actual;
  } hit_t;

  hit_t expected_hits[$];

  logic [lpv_pkg::TIME_BITS-1:0] center_q;
  logic [lpv_pkg::TIME_BITS-1:0] span_q;
  lpv_pkg::kind_t                kind_q;

  logic signed [lpv_pkg::DISPLAY_BITS-1:0] prev2_val;
  logic                                    prev2_good;
  logic [lpv_pkg::TIME_BITS-1:0]           mid_stamp;
  logic signed [lpv_pkg::DISPLAY_BITS-1:0] mid_val;
  logic signed [lpv_pkg::ACTUAL_BITS-1:0]  mid_act;
  logic                                    mid_has;
  logic                                    mid_good;
  int unsigned                             taken;
  hit_t                                    best;
  logic [lpv_pkg::TIME_BITS-1:0]           best_dist;

  int mismatches;
  int result_count;
  int hit_count;

  function automatic void clear_window();
    prev2_val  = '0;
    prev2_good = 1'b0;
    mid_stamp  = '0;
    mid_val    = '0;
    mid_act    = '0;
    mid_has    = 1'b0;
    mid_good   = 1'b0;
    taken      = 0;
    best       = '0;
    best_dist  = '1;
  endfunction

  // Decide whether the middle sample of the window replaces the kept candidate.
  function automatic void weigh_middle(
    input logic signed [lpv_pkg::DISPLAY_BITS-1:0] next_val,
    input logic next_good);
    logic [lpv_pkg::TIME_BITS-1:0]           gap;
    logic signed [lpv_pkg::DISPLAY_BITS-1:0] kept;
    logic                                    extreme;
    logic                                    better;
    if (!prev2_good || !mid_good || !next_good || span_q == '0) return;
    gap = (mid_stamp >= center_q) ? mid_stamp - center_q : center_q - mid_stamp;
    if (gap > span_q) return;
    if (kind_q == lpv_pkg::KIND_PEAK) extreme = (mid_val > prev2_val) && (mid_val > next_val);
    else extreme = (mid_val < prev2_val) && (mid_val < next_val);
    if (!extreme) return;
    kept = best.display;
    if (!best.found) better = 1'b1;
    else if (kind_q == lpv_pkg::KIND_PEAK ? mid_val > kept : mid_val < kept) better = 1'b1;
    else better = (mid_val == kept) && (gap < best_dist);
    if (better) begin
      best.found   = 1'b1;
      best.index   = lpv_pkg::INDEX_BITS'(taken - 1);
      best.stamp   = mid_stamp;
      best.display = mid_val;
      best.actual  = mid_has ? mid_act :
                     {{(lpv_pkg::ACTUAL_BITS-lpv_pkg::DISPLAY_BITS){mid_val[15]}}, mid_val};
      best_dist    = gap;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    hit_t want;
    hit_t entry;
    if (rst) begin
      center_q = '0;
      span_q   = '0;
      kind_q   = lpv_pkg::KIND_PEAK;
      clear_window();
      expected_hits.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          lpv_pkg::CFG_CENTER_TIME:  center_q = cfg.data;
          lpv_pkg::CFG_MAX_DISTANCE: span_q = cfg.data;
          lpv_pkg::CFG_EXTREME_KIND: kind_q = lpv_pkg::kind_t'(cfg.data[0]);
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        // Past the cap the window freezes, but a last flag still closes the stream.
        if (taken < SAMPLE_CAP) begin
          if (taken >= 2) weigh_middle(smp.sample_value, smp.usable);
          prev2_val  = mid_val;
          prev2_good = mid_good;
          mid_stamp  = smp.sample_time;
          mid_val    = smp.sample_value;
          mid_act    = smp.actual_value;
          mid_has    = smp.has_actual;
          mid_good   = smp.usable;
          taken++;
        end
        if (smp.last_sample) begin
          entry = best.found ? best : hit_t'('0);
          expected_hits = {expected_hits, entry};
          clear_window();
        end
      end
      if (res.valid && res.ready) begin
        result_count++;
        if (expected_hits.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_hits.pop_front();
          if (want.found) hit_count++;
          check_field("found", want.found, res.found);
          check_field("hit_index", want.index, res.hit_index);
          check_field("hit_time", want.stamp, res.hit_time);
          check_field("hit_display", want.display, res.hit_display);
          check_field("hit_actual", want.actual, res.hit_actual);
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_hits.size();
    results_seen <= result_count;
    hits_seen    <= hit_count;
  end

endmodule

[sim/testbench.sv]
// Top of the local peak/valley search regression: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on lpv_pkg, the three channel
// interfaces, local_peak_valley_in_window and lpv_hit_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_WORDS   = 120;
  localparam logic [lpv_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic        clk;
  logic        rst;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          words_sent = 0;
  int          streams_sent = 0;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          hits_seen;
  logic [lpv_pkg::TIME_BITS-1:0] cur_center;

  lpv_sample_if #(.VALUE_BITS(16)) smp ();
  lpv_result_if res ();
  lpv_cfg_if    cfg ();

  local_peak_valley_in_window u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .result  (res),
    .cfg     (cfg)
  );

  lpv_hit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp),
    .res          (res),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("local_peak_valley_in_window regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [lpv_pkg::TIME_BITS-1:0] t, input logic [15:0] v,
                           input logic [lpv_pkg::ACTUAL_BITS-1:0] a, input logic has_a,
                           input logic ok, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid        <= 1'b1;
    smp.sample_time  <= t;
    smp.sample_value <= v;
    smp.actual_value <= a;
    smp.has_actual   <= has_a;
    smp.usable       <= ok;
    smp.last_sample  <= last;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    words_sent++;
    if (last) streams_sent++;
  endtask

  // Hold the sender until every predicted result word is back, then let the pipe empty.
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lpv_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [lpv_pkg::CFG_DATA_BITS-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] center, input logic [31:0] span,
                            input logic [31:0] kind_word, input logic poke_unused);
    settle();
    write_reg(lpv_pkg::CFG_CENTER_TIME, center);
    write_reg(lpv_pkg::CFG_MAX_DISTANCE, span);
    write_reg(lpv_pkg::CFG_EXTREME_KIND, kind_word);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, $urandom());
    cfg.valid <= 1'b0;
    cur_center = center;
  endtask

  // Ascending times straddling the center, with values drawn to make peaks, valleys and ties.
  task automatic shaped_stream(input int len);
    logic [31:0]  step;
    logic [31:0]  t;
    logic [15:0]  v;
    int           shape;
    step  = $urandom_range(1, 64);
    t     = cur_center - step * len / 2 - $urandom_range(0, 8);
    shape = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = 16'(int'($urandom_range(6)) - 3);
        1: v = 16'($urandom());
        default: begin
          if ($urandom_range(1)) v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          else v = 16'($urandom());
        end
      endcase
      send_word(t, v, $urandom(), 1'($urandom_range(1)), $urandom_range(19) != 0,
                i == len - 1);
      t = t + step + ($urandom_range(3) == 0 ? $urandom_range(0, 32) : 0);
    end
  endtask

  task automatic noise_stream();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      send_word($urandom(), 16'($urandom()), $urandom(), 1'($urandom_range(1)),
                1'($urandom_range(1)), i == len - 1);
  endtask

  task automatic random_phase(input int idle, input int stall);
    logic [31:0] center;
    logic [31:0] span;
    int          stop;
    int          pick;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: center = '0;
        1: center = '1;
        default: center = $urandom();
      endcase
      case ($urandom_range(5))
        0: span = '0;
        1: span = 32'd1;
        2: span = '1;
        3: span = $urandom();
        default: span = $urandom_range(1, 2000);
      endcase
      set_config(center, span, $urandom(), $urandom_range(3) == 0);
      idle_pct  = idle;
      stall_pct = stall;
      stop = words_sent + PHASE_WORDS / 3;
      while (words_sent < stop) begin
        pick = $urandom_range(99);
        if (pick < 75) shaped_stream($urandom_range(3, 16));
        else if (pick < 83) shaped_stream($urandom_range(1, 2));
        else if (pick < 87) shaped_stream($urandom_range(30, 60));
        else noise_stream();
        if ($urandom_range(9) == 0) settle();
      end
    end
  endtask

  initial begin
    rst              <= 1'b1;
    smp.valid        <= 1'b0;
    smp.sample_time  <= '0;
    smp.sample_value <= '0;
    smp.actual_value <= '0;
    smp.has_actual   <= 1'b0;
    smp.usable       <= 1'b0;
    smp.last_sample  <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.index        <= '0;
    cfg.data         <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Peak search around 1000 within 100 ticks; the unused register index is poked too.
    set_config(32'd1000, 32'd100, 32'(lpv_pkg::KIND_PEAK), 1'b1);
    send_word(32'd1000, 16'd5, 32'd0, 1'b0, 1'b1, 1'b1);
    send_word(32'd990, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd1000, 16'd9, 32'd0, 1'b0, 1'b1, 1'b1);
    // Equal peaks: the one nearer the center wins, and it falls back to its display value.
    send_word(32'd900, 16'd0, 32'd1, 1'b1, 1'b1, 1'b0);
    send_word(32'd960, 16'd10, 32'hFFFF_FFF9, 1'b1, 1'b1, 1'b0);
    send_word(32'd1000, 16'd0, 32'd2, 1'b1, 1'b1, 1'b0);
    send_word(32'd1005, 16'd10, 32'h1234_5678, 1'b0, 1'b1, 1'b0);
    send_word(32'd1100, 16'd0, 32'd3, 1'b1, 1'b1, 1'b1);
    // Taller peak outside the window must lose to the lower one inside.
    send_word(32'd950, 16'h8000, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd1000, 16'd100, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    send_word(32'd1010, 16'h8000, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
    send_word(32'd1200, 16'h7FFF, 32'd0, 1'b1, 1'b1, 1'b0);
    send_word(32'd1210, 16'h8000, 32'd0, 1'b0, 1'b1, 1'b1);
    // Unusable right neighbour kills the peak.
    send_word(32'd990, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd1000, 16'd50, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd1010, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1);

    // Valley search with junk above the kind bit, widest window at the far end of time.
    set_config(32'd0, 32'hFFFF_FFFF, {31'h7FFF_FFFF, lpv_pkg::KIND_VALLEY}, 1'b0);
    send_word(32'hFFFF_FFFD, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFE, 16'h8000, 32'h0BAD_F00D, 1'b0, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 16'd0, 32'd0, 1'b1, 1'b1, 1'b1);

    // Zero distance disables the search even for a peak at the center.
    set_config(32'd0, 32'd0, 32'(lpv_pkg::KIND_PEAK), 1'b0);
    send_word(32'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd0, 16'd7, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b1);

    // Times that wrap past zero are far from a center near the top.
    set_config(32'hFFFF_FFF0, 32'h20, {31'h0000_0001, lpv_pkg::KIND_PEAK}, 1'b0);
    send_word(32'hFFFF_FFE8, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'hFFFF_FFF0, 16'd4, 32'hCAFE_0001, 1'b1, 1'b1, 1'b0);
    send_word(32'h0000_0004, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'h0000_0008, 16'd9, 32'd0, 1'b0, 1'b1, 1'b0);
    send_word(32'h0000_000C, 16'd0, 32'd0, 1'b0, 1'b1, 1'b1);

    random_phase(0, 0);
    random_phase(75, 0);
    random_phase(0, 75);
    random_phase(20, 20);
    settle();

    $display("sent %0d sample words in %0d streams over four handshake mixes",
             words_sent, streams_sent);
    $display("checked %0d result words, %0d of them with a hit", results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("local_peak_valley_in_window regression: pass");
    end else begin
      $display("local_peak_valley_in_window regression: fail");
    end
    $finish;
  end

endmodule
